>>> sv/token_bucket_packet_shaper_macros.svh
// ---------------------------------------------------------------------------
// Token bucket shaper assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the asynchronous reset is asserted.
// ---------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH
`define TOKEN_BUCKET_PACKET_SHAPER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TBPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TBPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/tbps_pkg.sv
// ---------------------------------------------------------------------------
// Token bucket shaper package
// Field widths, reset values, status codes and the queue entry layout.
// ---------------------------------------------------------------------------
package tbps_pkg;

	localparam int BUCKET_W        = 10;
	localparam int TAG_W           = 16;
	localparam int FILL_W          = 7;
	localparam int STATUS_W        = 3;
	localparam int ENTRY_W         = TAG_W + BUCKET_W;
	localparam int DEF_QUEUE_DEPTH = 64;

	localparam logic [BUCKET_W-1:0] RESET_DEPTH = 10'd10;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_TOKEN_ADDED   = 3'd0,
		ST_TOKEN_DROPPED = 3'd1,
		ST_TOO_BIG       = 3'd2,
		ST_QUEUED        = 3'd3,
		ST_RELEASED      = 3'd4,
		ST_QUEUE_FULL    = 3'd5
	} status_t;

	// One waiting packet
	typedef struct packed {
		logic [TAG_W-1:0]    tag;
		logic [BUCKET_W-1:0] need;
	} q_entry_t;

endpackage

>>> sv/tbps_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
module tbps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/token_bucket_packet_shaper.sv
// Result path: start is registered into the input stage, and done is registered from it in the result stage.
// Throughput: one event per cycle; busy never rises and results cannot be stalled.
// Waiting queue: two head registers in front of a RAM with registered read.
// Reset: asynchronous, clears the bucket level, the queue and sets bucket_depth to 10.
// Queue RAM contents are not cleared; no clearing pass is needed after reset.
// ---------------------------------------------------------------------------
// Token bucket packet shaper
// Adds tokens to a bucket up to a configurable depth and releases packets
// directly or through a FIFO of waiting packets once enough tokens are in.
// ---------------------------------------------------------------------------
`include "token_bucket_packet_shaper_macros.svh"

module token_bucket_packet_shaper
	import tbps_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// event request
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [TAG_W-1:0]    packet_tag,
	input  logic [BUCKET_W-1:0] tokens_wanted,
	// bucket depth write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [BUCKET_W-1:0] cfg_wdata,
	// result
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [TAG_W-1:0]    released_tag,
	output logic [BUCKET_W-1:0] tokens_now,
	output logic [FILL_W-1:0]   queue_fill
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	// Configuration and bucket state
	logic [BUCKET_W-1:0] depth_q;
	logic [BUCKET_W-1:0] level_q;
	logic [BUCKET_W-1:0] level_d;
	logic [BUCKET_W-1:0] lvl_inc;

	// Input stage
	logic                valid_s1;
	logic                mode_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic [BUCKET_W-1:0] need_s1;

	// Result stage
	logic                done_s2;
	status_t             status_s2;
	logic [TAG_W-1:0]    rtag_s2;
	logic [BUCKET_W-1:0] tokens_s2;
	logic [FILL_W-1:0]   fill_s2;

	// Event decision
	status_t             status_c;
	logic [TAG_W-1:0]    rtag_c;
	logic                pop;
	logic                push;

	// Queue: head slots, RAM pointers and counts
	q_entry_t            s0_q, s1_q, n0, n1, new_entry;
	logic                s0_vld_q, s1_vld_q, n0v, n1v;
	logic                pend_q;
	logic [AW-1:0]       wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]       count_q, count_d;
	logic [CW-1:0]       ram_cnt_q;
	logic                ram_we, rd_en;
	logic [ENTRY_W-1:0]  ram_rdata;
	q_entry_t            land_entry;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign new_entry = '{tag: tag_s1, need: need_s1};
	assign land_entry = q_entry_t'(ram_rdata);

	// Per-event token and queue decision
	always_comb begin
		lvl_inc  = level_q + BUCKET_W'(1);
		status_c = ST_TOKEN_ADDED;
		rtag_c   = '0;
		level_d  = level_q;
		pop      = 1'b0;
		push     = 1'b0;
		if (valid_s1) begin
			if (!mode_s1) begin
				if (level_q >= depth_q) begin
					status_c = ST_TOKEN_DROPPED;
				end else begin
					level_d = lvl_inc;
					if (count_q != '0 && lvl_inc >= s0_q.need) begin
						level_d  = lvl_inc - s0_q.need;
						rtag_c   = s0_q.tag;
						pop      = 1'b1;
						status_c = ST_RELEASED;
					end
				end
			end else begin
				rtag_c = tag_s1;
				if (need_s1 > depth_q) begin
					status_c = ST_TOO_BIG;
				end else if (count_q == '0 && level_q >= need_s1) begin
					level_d  = level_q - need_s1;
					status_c = ST_RELEASED;
				end else if (count_q == CW'(QUEUE_DEPTH)) begin
					status_c = ST_QUEUE_FULL;
				end else begin
					push     = 1'b1;
					status_c = ST_QUEUED;
				end
			end
		end
	end

	// Head slot refill: pop, then RAM read data, then a direct push
	always_comb begin
		n0     = s0_q;
		n0v    = s0_vld_q;
		n1     = s1_q;
		n1v    = s1_vld_q;
		ram_we = 1'b0;
		if (pop) begin
			n0  = s1_q;
			n0v = s1_vld_q;
			n1v = 1'b0;
		end
		if (pend_q) begin
			if (!n0v) begin
				n0  = land_entry;
				n0v = 1'b1;
			end else begin
				n1  = land_entry;
				n1v = 1'b1;
			end
		end
		if (push) begin
			if (ram_cnt_q == '0 && !n0v) begin
				n0  = new_entry;
				n0v = 1'b1;
			end else if (ram_cnt_q == '0 && !n1v) begin
				n1  = new_entry;
				n1v = 1'b1;
			end else begin
				ram_we = 1'b1;
			end
		end
		rd_en   = (ram_cnt_q != '0) && !(n0v && n1v);
		count_d = count_q + CW'(push) - CW'(pop);
	end

	// Backing store for waiting packets
	tbps_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wr_ptr_q),
		.wdata (new_entry),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q   <= RESET_DEPTH;
			level_q   <= '0;
			valid_s1  <= 1'b0;
			done_s2   <= 1'b0;
			s0_vld_q  <= 1'b0;
			s1_vld_q  <= 1'b0;
			pend_q    <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			count_q   <= '0;
			ram_cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				depth_q <= cfg_wdata;
			end
			valid_s1  <= start && !busy;
			done_s2   <= valid_s1;
			level_q   <= level_d;
			s0_vld_q  <= n0v;
			s1_vld_q  <= n1v;
			pend_q    <= rd_en;
			count_q   <= count_d;
			ram_cnt_q <= ram_cnt_q + CW'(ram_we) - CW'(rd_en);
			if (ram_we) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			mode_s1 <= mode;
			tag_s1  <= packet_tag;
			need_s1 <= tokens_wanted;
		end
		s0_q <= n0;
		s1_q <= n1;
		if (valid_s1) begin
			status_s2 <= status_c;
			rtag_s2   <= rtag_c;
			tokens_s2 <= level_d;
			fill_s2   <= FILL_W'(count_d);
		end
	end

	assign done         = done_s2;
	assign status       = status_s2;
	assign released_tag = rtag_s2;
	assign tokens_now   = tokens_s2;
	assign queue_fill   = fill_s2;

	// Checks
	`TBPS_ASSERT_NOW(a_head_present, clk, arst_n, count_q != '0, s0_vld_q, "queue head slot empty")
	`TBPS_ASSERT_NOW(a_land_room, clk, arst_n, pend_q, !(s0_vld_q && s1_vld_q), "no slot for RAM data")
	`TBPS_ASSERT_NOW(a_count_sum, clk, arst_n, 1'b1, count_q == CW'(s0_vld_q) + CW'(s1_vld_q) + CW'(pend_q) + ram_cnt_q, "queue count mismatch")
	`TBPS_ASSERT_NOW(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH), "queue count overflow")
	`TBPS_ASSERT_NEXT(a_one_result, clk, arst_n, valid_s1, done_s2, "event without result")

endmodule
